FILE: design/euler_angles_to_basis_vectors_defines.svh
// assertion macros for the euler angles to basis vectors block
// expects clk and arst_n in the scope of each use
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define EA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ea2bv_pkg.sv
// shared types, constants and arithmetic helpers for the basis vector block
// no dependencies
`timescale 1ns / 1ps

package ea2bv_pkg;

	localparam int ANGLE_WIDTH  = 16;
	localparam int VECTOR_WIDTH = 16;
	localparam int Q_FRAC       = 30;
	localparam int OUT_FRAC     = VECTOR_WIDTH - 1;
	localparam int OUT_SH       = Q_FRAC - OUT_FRAC;

	localparam logic [17:0] ANG_BIAS  = 18'd46080;
	localparam logic [16:0] ANG_FULL  = 17'd23040;
	localparam logic [16:0] ANG_QUART = 17'd5760;
	localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;

	localparam logic [13:0] DIV45_MUL = 14'd11651;
	localparam int          DIV45_SH  = 19;
	localparam int          FRAC_DIV  = 45;
	localparam int          XF_DEPTH  = 64;

	localparam int NUM_CELLS  = 5;
	localparam int CELL_IDX_W = 3;

	localparam logic [30:0] T_ONE = 31'd1 << Q_FRAC;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef struct packed {
		quad_t       quad;
		logic [30:0] x;
		logic [31:0] x2;
		logic [30:0] t;
	} hc_t;

	typedef struct packed {
		logic signed [31:0] sn;
		logic signed [31:0] cs;
	} sc_t;

	typedef struct packed {
		logic [VECTOR_WIDTH-1:0] fwd_x;
		logic [VECTOR_WIDTH-1:0] fwd_y;
		logic [VECTOR_WIDTH-1:0] fwd_z;
		logic [VECTOR_WIDTH-1:0] rgt_x;
		logic [VECTOR_WIDTH-1:0] rgt_y;
		logic [VECTOR_WIDTH-1:0] rgt_z;
		logic [VECTOR_WIDTH-1:0] up_x;
		logic [VECTOR_WIDTH-1:0] up_y;
		logic [VECTOR_WIDTH-1:0] up_z;
	} vec_t;

	// divisor k*(k+1) of each taylor step, k = 10, 8, 6, 4, 2
	function automatic logic [6:0] hc_div(input logic [CELL_IDX_W-1:0] idx);
		case (idx)
			3'd0:    return 7'd110;
			3'd1:    return 7'd72;
			3'd2:    return 7'd42;
			3'd3:    return 7'd20;
			default: return 7'd6;
		endcase
	endfunction

	// floor(2^32 / divisor)
	function automatic logic [29:0] hc_recip(input logic [CELL_IDX_W-1:0] idx);
		case (idx)
			3'd0:    return 30'd39045157;
			3'd1:    return 30'd59652323;
			3'd2:    return 30'd102261126;
			3'd3:    return 30'd214748364;
			default: return 30'd715827882;
		endcase
	endfunction

	// fraction part of the angle to radian scaling, constant table over b
	function automatic logic [XF_DEPTH*32-1:0] xf_build();
		logic [XF_DEPTH*32-1:0] tab;
		logic [37:0]            num;
		for (int b = 0; b < XF_DEPTH; b++) begin
			num = 38'(b) * 38'(PI_Q30) + 38'(ANG_QUART);
			tab[b*32 +: 32] = 32'(num / FRAC_DIV);
		end
		return tab;
	endfunction

	localparam logic [XF_DEPTH*32-1:0] XF_TAB = xf_build();

	function automatic logic [31:0] x_frac(input logic [5:0] b);
		return XF_TAB[{b, 5'd0} +: 32];
	endfunction

	// q30 product, rounded half away from zero on magnitudes
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic        neg;
		logic [30:0] ua;
		logic [30:0] ub;
		logic [62:0] p;
		neg = a[31] ^ b[31];
		ua  = a[31] ? 31'(-a) : 31'(a);
		ub  = b[31] ? 31'(-b) : 31'(b);
		p   = 63'(ua) * 63'(ub) + (63'd1 << (Q_FRAC - 1));
		return neg ? -32'(p[62:Q_FRAC]) : 32'(p[62:Q_FRAC]);
	endfunction

	// q30 to output format with rounding and saturation
	function automatic logic [VECTOR_WIDTH-1:0] to_out(input logic signed [33:0] v);
		logic        neg;
		logic [33:0] mag;
		logic [34:0] sum;
		logic [33:0] rnd;
		neg = v[33];
		mag = neg ? 34'(-v) : 34'(v);
		sum = 35'(mag) + (35'd1 << (OUT_SH - 1));
		rnd = 34'(sum >> OUT_SH);
		if (!neg && rnd > ((34'd1 << OUT_FRAC) - 34'd1))
			return VECTOR_WIDTH'((34'd1 << OUT_FRAC) - 34'd1);
		else if (neg && rnd > (34'd1 << OUT_FRAC))
			return VECTOR_WIDTH'(34'd1 << OUT_FRAC);
		else
			return neg ? VECTOR_WIDTH'(-rnd) : VECTOR_WIDTH'(rnd);
	endfunction

endpackage

FILE: design/ea2bv_ang_if.sv
// request channel carrying one pitch, yaw, roll triple
// depends on ea2bv_pkg
`timescale 1ns / 1ps

interface ea2bv_ang_if import ea2bv_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] pitch_deg;
	logic signed [ANGLE_WIDTH-1:0] yaw_deg;
	logic signed [ANGLE_WIDTH-1:0] roll_deg;

	modport source (output valid, pitch_deg, yaw_deg, roll_deg, input ready);
	modport sink (input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface

FILE: design/ea2bv_vec_if.sv
// result channel carrying the forward, right and up vectors
// depends on ea2bv_pkg
`timescale 1ns / 1ps

interface ea2bv_vec_if import ea2bv_pkg::*;;
	logic                           valid;
	logic                           ready;
	logic signed [VECTOR_WIDTH-1:0] fwd_x;
	logic signed [VECTOR_WIDTH-1:0] fwd_y;
	logic signed [VECTOR_WIDTH-1:0] fwd_z;
	logic signed [VECTOR_WIDTH-1:0] rgt_x;
	logic signed [VECTOR_WIDTH-1:0] rgt_y;
	logic signed [VECTOR_WIDTH-1:0] rgt_z;
	logic signed [VECTOR_WIDTH-1:0] up_x;
	logic signed [VECTOR_WIDTH-1:0] up_y;
	logic signed [VECTOR_WIDTH-1:0] up_z;

	modport source (output valid, fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z,
		up_x, up_y, up_z, output ready);
endinterface

FILE: design/ea2bv_hcell.sv
// one taylor step of the first quadrant sine, three register stages
// depends on ea2bv_pkg
`timescale 1ns / 1ps

module ea2bv_hcell import ea2bv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [CELL_IDX_W-1:0] step,
	input  logic                  din_vld,
	input  hc_t                   din,
	output logic                  dout_vld,
	output hc_t                   dout
);

	logic        vld_s1;
	logic        vld_s2;
	hc_t         a_s1;
	hc_t         b_s2;
	logic [62:0] prod_s1;
	logic [31:0] n_s2;
	logic [29:0] q0_s2;

	logic [6:0]  dv;
	logic [29:0] rcp;
	logic [63:0] prod_rnd;
	logic [31:0] n_d;
	logic [61:0] qm;
	logic [38:0] q0d;
	logic [31:0] rem;
	logic [31:0] q_d;

	assign dv  = hc_div(step);
	assign rcp = hc_recip(step);

	always_comb begin
		prod_rnd = 64'(prod_s1) + (64'd1 << (Q_FRAC - 1));
		n_d      = 32'(prod_rnd >> Q_FRAC) + 32'(dv >> 1);
		qm       = 62'(n_d) * 62'(rcp);
	end

	// reciprocal estimate is low by at most one
	always_comb begin
		q0d = 39'(q0_s2) * 39'(dv);
		rem = 32'(39'(n_s2) - q0d);
		q_d = (rem >= 32'(dv)) ? 32'(q0_s2) + 32'd1 : 32'(q0_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			dout_vld <= 1'b0;
		end else if (en) begin
			vld_s1   <= din_vld;
			vld_s2   <= vld_s1;
			dout_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= din;
			prod_s1 <= 63'(din.x2) * 63'(din.t);
			b_s2    <= a_s1;
			n_s2    <= n_d;
			q0_s2   <= 30'(qm >> 32);
			dout    <= '{quad: b_s2.quad, x: b_s2.x, x2: b_s2.x2,
				t: 31'(32'(T_ONE) - q_d)};
		end
	end

endmodule

FILE: design/ea2bv_sincos.sv
// sine and cosine of one angle: reduction, scaling, two chains of taylor cells
// depends on ea2bv_pkg and ea2bv_hcell
`timescale 1ns / 1ps

module ea2bv_sincos import ea2bv_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          ang_vld,
	input  logic signed [ANGLE_WIDTH-1:0] ang,
	output logic                          sc_vld,
	output sc_t                           sc
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	quad_t       quad_s1, quad_s2, quad_s3, quad_s5;
	logic [12:0] r_s1;
	logic [12:0] u_s2 [2];
	logic [7:0]  a_s2 [2];
	logic [30:0] x_s3 [2];
	hc_t         hc_s4 [2];
	logic [30:0] s_s5 [2];

	logic [17:0] w0;
	logic [16:0] w1, w2, w3, w4;
	quad_t       quad_d;
	logic [16:0] r_d;

	hc_t  chain [2][NUM_CELLS+1];
	logic cvld  [2][NUM_CELLS+1];

	// wrap into one turn, then split into quadrant and remainder
	always_comb begin
		w0 = 18'(ang) + ANG_BIAS;
		w1 = 17'(w0);
		w2 = (w1 >= ANG_FULL) ? w1 - ANG_FULL : w1;
		w3 = (w2 >= ANG_FULL) ? w2 - ANG_FULL : w2;
		w4 = (w3 >= ANG_FULL) ? w3 - ANG_FULL : w3;
		if (w4 >= 17'(3) * ANG_QUART) begin
			quad_d = QUAD_IV;
			r_d    = w4 - 17'(3) * ANG_QUART;
		end else if (w4 >= 17'(2) * ANG_QUART) begin
			quad_d = QUAD_III;
			r_d    = w4 - 17'(2) * ANG_QUART;
		end else if (w4 >= ANG_QUART) begin
			quad_d = QUAD_II;
			r_d    = w4 - ANG_QUART;
		end else begin
			quad_d = QUAD_I;
			r_d    = w4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			sc_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= ang_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= cvld[0][NUM_CELLS];
			sc_vld <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= quad_d;
			r_s1    <= 13'(r_d);
			quad_s2 <= quad_s1;
			quad_s3 <= quad_s2;
			quad_s5 <= chain[0][NUM_CELLS].quad;
		end
	end

	// lane 0 works on r for the sine, lane 1 on a quarter turn minus r
	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [12:0] u_d;
		logic [26:0] a_prod;
		logic [5:0]  b_d;
		logic [40:0] x_sum;
		logic [63:0] x2_prod;
		logic [62:0] s_prod;
		logic [30:0] s_d;

		always_comb begin
			u_d     = (l == 0) ? r_s1 : 13'(ANG_QUART - 17'(r_s1));
			a_prod  = 27'(u_d) * 27'(DIV45_MUL);
			b_d     = 6'(u_s2[l] - 13'(13'(a_s2[l]) * 13'(FRAC_DIV)));
			x_sum   = 41'(a_s2[l]) * 41'(PI_Q30) + 41'(x_frac(b_d));
			x2_prod = 64'(x_s3[l]) * 64'(x_s3[l]) + (64'd1 << (Q_FRAC - 1));
			s_prod  = 63'(chain[l][NUM_CELLS].x) * 63'(chain[l][NUM_CELLS].t)
				+ (63'd1 << (Q_FRAC - 1));
			s_d     = (s_prod[62:Q_FRAC] > 33'(T_ONE)) ? T_ONE : 31'(s_prod[62:Q_FRAC]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				u_s2[l]  <= u_d;
				a_s2[l]  <= 8'(a_prod >> DIV45_SH);
				x_s3[l]  <= 31'(x_sum >> 8);
				hc_s4[l] <= '{quad: quad_s3, x: x_s3[l],
					x2: 32'(x2_prod >> Q_FRAC), t: T_ONE};
				s_s5[l]  <= s_d;
			end
		end

		assign chain[l][0] = hc_s4[l];
		assign cvld[l][0]  = vld_s4;

		for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
			ea2bv_hcell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.step     (CELL_IDX_W'(c)),
				.din_vld  (cvld[l][c]),
				.din      (chain[l][c]),
				.dout_vld (cvld[l][c+1]),
				.dout     (chain[l][c+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s5)
				QUAD_I: begin
					sc.sn <= 32'(s_s5[0]);
					sc.cs <= 32'(s_s5[1]);
				end
				QUAD_II: begin
					sc.sn <= 32'(s_s5[1]);
					sc.cs <= -32'(s_s5[0]);
				end
				QUAD_III: begin
					sc.sn <= -32'(s_s5[0]);
					sc.cs <= -32'(s_s5[1]);
				end
				default: begin
					sc.sn <= -32'(s_s5[1]);
					sc.cs <= 32'(s_s5[0]);
				end
			endcase
		end
	end

endmodule

FILE: design/euler_angles_to_basis_vectors.sv
// throughput: one request per cycle while the pipeline is not stalled, set by the fully pipelined taylor cell chains
// a waiting result stalls the whole pipeline once the one skid entry behind the output fills
// reset: asynchronous active low, clears all valid bits; payload is not reset
// top level, depends on ea2bv_pkg, the channel interfaces and ea2bv_sincos
`timescale 1ns / 1ps
`include "euler_angles_to_basis_vectors_defines.svh"

module euler_angles_to_basis_vectors import ea2bv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ea2bv_ang_if.sink    ang,
	ea2bv_vec_if.source  vec
);

	logic en;
	logic vld_p, vld_y, vld_r;
	sc_t  sc_p, sc_y, sc_r;

	logic               vld_s1, vld_s2;
	logic signed [31:0] srsp_s1, crsp_s1, cpcy_s1, cpsy_s1, srcp_s1, crcp_s1;
	logic signed [31:0] crsy_s1, crcy_s1, srsy_s1, srcy_s1, sp_s1, sy_s1, cy_s1;
	logic signed [31:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [31:0] cpcy_s2, cpsy_s2, srcp_s2, crcp_s2, sp_s2;
	logic signed [31:0] crsy_s2, crcy_s2, srsy_s2, srcy_s2;

	vec_t res;
	vec_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;

	assign en        = !skid_vld_q;
	assign ang.ready = en;

	ea2bv_sincos u_sc_pitch (
		.clk (clk), .arst_n (arst_n), .en (en), .ang_vld (ang.valid),
		.ang (ang.pitch_deg), .sc_vld (vld_p), .sc (sc_p)
	);

	ea2bv_sincos u_sc_yaw (
		.clk (clk), .arst_n (arst_n), .en (en), .ang_vld (ang.valid),
		.ang (ang.yaw_deg), .sc_vld (vld_y), .sc (sc_y)
	);

	ea2bv_sincos u_sc_roll (
		.clk (clk), .arst_n (arst_n), .en (en), .ang_vld (ang.valid),
		.ang (ang.roll_deg), .sc_vld (vld_r), .sc (sc_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_p;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s1 <= mulq(sc_r.sn, sc_p.sn);
			crsp_s1 <= mulq(sc_r.cs, sc_p.sn);
			cpcy_s1 <= mulq(sc_p.cs, sc_y.cs);
			cpsy_s1 <= mulq(sc_p.cs, sc_y.sn);
			srcp_s1 <= mulq(sc_r.sn, sc_p.cs);
			crcp_s1 <= mulq(sc_r.cs, sc_p.cs);
			crsy_s1 <= mulq(sc_r.cs, sc_y.sn);
			crcy_s1 <= mulq(sc_r.cs, sc_y.cs);
			srsy_s1 <= mulq(sc_r.sn, sc_y.sn);
			srcy_s1 <= mulq(sc_r.sn, sc_y.cs);
			sp_s1   <= sc_p.sn;
			sy_s1   <= sc_y.sn;
			cy_s1   <= sc_y.cs;

			m1_s2   <= mulq(srsp_s1, cy_s1);
			m2_s2   <= mulq(srsp_s1, sy_s1);
			m3_s2   <= mulq(crsp_s1, cy_s1);
			m4_s2   <= mulq(crsp_s1, sy_s1);
			cpcy_s2 <= cpcy_s1;
			cpsy_s2 <= cpsy_s1;
			srcp_s2 <= srcp_s1;
			crcp_s2 <= crcp_s1;
			sp_s2   <= sp_s1;
			crsy_s2 <= crsy_s1;
			crcy_s2 <= crcy_s1;
			srsy_s2 <= srsy_s1;
			srcy_s2 <= srcy_s1;
		end
	end

	always_comb begin
		res.fwd_x = to_out(34'(cpcy_s2));
		res.fwd_y = to_out(34'(cpsy_s2));
		res.fwd_z = to_out(-34'(sp_s2));
		res.rgt_x = to_out(34'(crsy_s2) - 34'(m1_s2));
		res.rgt_y = to_out(-34'(m2_s2) - 34'(crcy_s2));
		res.rgt_z = to_out(-34'(srcp_s2));
		res.up_x  = to_out(34'(m3_s2) + 34'(srsy_s2));
		res.up_y  = to_out(34'(m4_s2) - 34'(srcy_s2));
		res.up_z  = to_out(34'(crcp_s2));
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || vec.ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s2;
			end
		end else if (vld_s2 && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || vec.ready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (vld_s2 && en) begin
			skid_q <= res;
		end
	end

	assign vec.valid = out_vld_q;
	assign vec.fwd_x = out_q.fwd_x;
	assign vec.fwd_y = out_q.fwd_y;
	assign vec.fwd_z = out_q.fwd_z;
	assign vec.rgt_x = out_q.rgt_x;
	assign vec.rgt_y = out_q.rgt_y;
	assign vec.rgt_z = out_q.rgt_z;
	assign vec.up_x  = out_q.up_x;
	assign vec.up_y  = out_q.up_y;
	assign vec.up_z  = out_q.up_z;

	`EA_ASSERT_IMPL(a_lanes_agree, 1'b1, (vld_p == vld_y) && (vld_p == vld_r), "angle lanes out of step")
	`EA_ASSERT_IMPL(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry without output entry")
	`EA_ASSERT_NEXT(a_skid_drains, skid_vld_q && vec.ready, !skid_vld_q, "skid entry not drained")

endmodule

FILE: tb/ea2bv_tb_if.sv
// channel interfaces for the basis vector testbench are the design's own
// this file holds the testbench-side request record shared by driver and initial block
// depends on ea2bv_pkg
`timescale 1ns / 1ps

package ea2bv_tb_pkg;
	import ea2bv_pkg::*;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] pitch;
		logic signed [ANGLE_WIDTH-1:0] yaw;
		logic signed [ANGLE_WIDTH-1:0] roll;
	} angles_t;
endpackage

FILE: tb/euler_angles_to_basis_vectors_tb.sv
// testbench for euler_angles_to_basis_vectors: random and directed angle triples,
// expected vectors from an independent fixed-point predictor, checked in order
// depends on ea2bv_pkg, ea2bv_tb_pkg, the channel interfaces and the block
`timescale 1ns / 1ps

module euler_angles_to_basis_vectors_tb;
	import ea2bv_pkg::*;
	import ea2bv_tb_pkg::*;

	localparam int LATENCY = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	bit quiet = 1'b0;

	angles_t pending_q[$];
	vec_t expected_q[$];

	ea2bv_ang_if ang ();
	ea2bv_vec_if vec ();

	euler_angles_to_basis_vectors i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.ang(ang),
		.vec(vec)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned q30_round(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint quarter_sine(longint u);
		longint unsigned x, x2, t, d, v, s;
		x = (longint'(u) * 64'hC90FDAA2 + 5760) / 11520;
		x2 = q30_round(x, x);
		t = 64'd1 << 30;
		for (int k = 10; k >= 2; k -= 2) begin
			d = k * (k + 1);
			v = q30_round(x2, t);
			t = (64'd1 << 30) - (v + d / 2) / d;
		end
		s = q30_round(x, t);
		if (s > (64'd1 << 30))
			s = 64'd1 << 30;
		return longint'(s);
	endfunction

	function automatic void angle_sincos(input logic signed [ANGLE_WIDTH-1:0] raw,
		output longint sn, output longint cs);
		longint a, r, s0, c0;
		a = longint'(raw) % 23040;
		if (a < 0)
			a += 23040;
		r = a % 5760;
		s0 = quarter_sine(r);
		c0 = quarter_sine(5760 - r);
		case (a / 5760)
			0: begin sn = s0; cs = c0; end
			1: begin sn = c0; cs = -s0; end
			2: begin sn = -s0; cs = -c0; end
			default: begin sn = -c0; cs = s0; end
		endcase
	endfunction

	function automatic longint prod_q30(longint a, longint b);
		longint p;
		p = longint'(q30_round((a < 0) ? -a : a, (b < 0) ? -b : b));
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	function automatic logic [VECTOR_WIDTH-1:0] scale_out(longint v);
		longint m, hi, lo;
		longint unsigned mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'd1 << (30 - VECTOR_WIDTH))) >> (31 - VECTOR_WIDTH);
		m = (v < 0) ? -longint'(mag) : longint'(mag);
		hi = (64'sd1 <<< (VECTOR_WIDTH - 1)) - 1;
		lo = -(64'sd1 <<< (VECTOR_WIDTH - 1));
		if (m > hi)
			m = hi;
		if (m < lo)
			m = lo;
		return VECTOR_WIDTH'(m);
	endfunction

	function automatic vec_t basis_of(angles_t a);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		vec_t b;
		angle_sincos(a.pitch, sp, cp);
		angle_sincos(a.yaw, sy, cy);
		angle_sincos(a.roll, sr, cr);
		srsp = prod_q30(sr, sp);
		crsp = prod_q30(cr, sp);
		b.fwd_x = scale_out(prod_q30(cp, cy));
		b.fwd_y = scale_out(prod_q30(cp, sy));
		b.fwd_z = scale_out(-sp);
		b.rgt_x = scale_out(-prod_q30(srsp, cy) + prod_q30(cr, sy));
		b.rgt_y = scale_out(-prod_q30(srsp, sy) - prod_q30(cr, cy));
		b.rgt_z = scale_out(-prod_q30(sr, cp));
		b.up_x = scale_out(prod_q30(crsp, cy) + prod_q30(sr, sy));
		b.up_y = scale_out(prod_q30(crsp, sy) - prod_q30(sr, cy));
		b.up_z = scale_out(prod_q30(cr, cp));
		return b;
	endfunction

	task automatic report(input string what, input logic [VECTOR_WIDTH-1:0] got,
		input logic [VECTOR_WIDTH-1:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what,
			$signed(got), $signed(want), $realtime);
	endtask

	function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return ANGLE_WIDTH'($urandom_range(0, 8) * 5760 + $urandom_range(0, 2) - 1);
			1: return -ANGLE_WIDTH'($urandom_range(0, 5) * 5760);
			default: return ANGLE_WIDTH'($urandom());
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		angles_t nxt;
		if (!arst_n) begin
			ang.valid <= 1'b0;
			ang.pitch_deg <= '0;
			ang.yaw_deg <= '0;
			ang.roll_deg <= '0;
		end else if (!ang.valid || ang.ready) begin
			if (ang.valid)
				expected_q.push_back(basis_of({ang.pitch_deg, ang.yaw_deg, ang.roll_deg}));
			if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 28)) begin
				nxt = pending_q.pop_front();
				ang.valid <= 1'b1;
				ang.pitch_deg <= nxt.pitch;
				ang.yaw_deg <= nxt.yaw;
				ang.roll_deg <= nxt.roll;
			end else begin
				ang.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		vec_t want;
		if (!arst_n) begin
			vec.ready <= 1'b0;
		end else begin
			if (vec.valid && vec.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("unexpected result at %0t", $realtime);
				end else begin
					want = expected_q.pop_front();
					if (vec.fwd_x !== want.fwd_x) report("fwd_x", vec.fwd_x, want.fwd_x);
					if (vec.fwd_y !== want.fwd_y) report("fwd_y", vec.fwd_y, want.fwd_y);
					if (vec.fwd_z !== want.fwd_z) report("fwd_z", vec.fwd_z, want.fwd_z);
					if (vec.rgt_x !== want.rgt_x) report("rgt_x", vec.rgt_x, want.rgt_x);
					if (vec.rgt_y !== want.rgt_y) report("rgt_y", vec.rgt_y, want.rgt_y);
					if (vec.rgt_z !== want.rgt_z) report("rgt_z", vec.rgt_z, want.rgt_z);
					if (vec.up_x !== want.up_x) report("up_x", vec.up_x, want.up_x);
					if (vec.up_y !== want.up_y) report("up_y", vec.up_y, want.up_y);
					if (vec.up_z !== want.up_z) report("up_z", vec.up_z, want.up_z);
				end
			end
			vec.ready <= quiet || $urandom_range(0, 99) >= 28;
		end
	end

	initial begin
		angles_t a;
		logic signed [ANGLE_WIDTH-1:0] edges[12];
		edges = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1,
			16'sd1, 16'sd5760, 16'sd11520, 16'sd17280, 16'sd23040, -16'sd5760, 16'sd23039,
			-16'sd23040};
		for (int i = 0; i < 12; i++)
			pending_q.push_back({edges[i], edges[(i + 5) % 12], edges[(i + 9) % 12]});
		pending_q.push_back({16'sd5760, 16'sd0, 16'sd0});
		pending_q.push_back({-16'sd5760, 16'sd5760, 16'sd17280});
		pending_q.push_back({16'sd2880, 16'sd2880, 16'sd2880});
		pending_q.push_back({16'sh5555, -16'sh5556, 16'sh2AAA});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 640; i++) begin
			if (i == 200)
				quiet = 1'b1;
			if (i == 330)
				quiet = 1'b0;
			a.pitch = rand_angle();
			a.yaw = rand_angle();
			a.roll = rand_angle();
			pending_q.push_back(a);
			if (pending_q.size() > 8)
				while (pending_q.size() > 4)
					@(posedge clk);
		end
		while (pending_q.size() != 0 || ang.valid)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("euler_angles_to_basis_vectors verification clean");
		else
			$display("euler_angles_to_basis_vectors verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("euler_angles_to_basis_vectors verification failed");
		$finish;
	end

endmodule
